// File: rtl/lmf_pkg.sv
// Shared types and constants of the lane marking filter.
package lmf_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_DISTANCE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH    = 1'b1;

    // Register widths and values after reset.
    localparam int TAP_REG_W   = 5;
    localparam int WIDTH_REG_W = 12;
    localparam int CFG_DATA_W  = 12;
    localparam logic [TAP_REG_W-1:0]   TAP_RESET   = 5'd20;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 12'd640;

    // Pixel and marking widths.
    localparam int PIX_W = 8;

    // Border count: wide enough for the largest tap distance of any build.
    localparam int FLUSH_W = 6;

    // One pending result group handed from the datapath to the output sequencer.
    typedef struct packed {
        logic               first;      // a centered result is pending
        logic [PIX_W-1:0]   mark;       // strength of the centered result
        logic               first_rend; // centered result closes the row
        logic [FLUSH_W-1:0] flush;      // trailing border zeros still to send
    } t_job;

endpackage

// File: rtl/lmf_window_mem.sv
// Circular pixel window memory: one write port and two registered read ports.
module lmf_window_mem #(
    parameter int AW = 6,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/lmf_result_seq.sv
// Output sequencer: sends the centered result and the trailing border zeros.
module lmf_result_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  lmf_pkg::t_job                i_job,
    output logic                         o_free,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lmf_pkg::PIX_W-1:0]    o_mark,
    output logic                         o_row_end,
    output logic                         o_last
);
    import lmf_pkg::*;

    logic r_valid;
    t_job r_job;
    logic n_valid;
    t_job n_job;
    logic handshake;
    logic flush_one;

    // Result fields of the request at the head.
    assign flush_one = (r_job.flush == FLUSH_W'(1));
    assign handshake = r_valid && i_ready;
    assign o_valid   = r_valid;
    assign o_mark    = r_job.first ? r_job.mark : '0;
    assign o_row_end = r_job.first ? r_job.first_rend : flush_one;
    assign o_last    = r_job.first ? (r_job.flush == '0) : flush_one;
    assign o_free    = !r_valid || (handshake && o_last);

    // Step through the group, one result per request.
    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (handshake) begin
            if (r_job.first) begin
                n_job.first = 1'b0;
            end else begin
                n_job.flush = r_job.flush - FLUSH_W'(1);
            end
            if (o_last) begin
                n_valid = 1'b0;
            end
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_job   = i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

`ifndef NO_ASSERTIONS
    a_pending_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_job.first |-> r_job.flush != '0)
        else $error("pending group holds no result");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("group loaded over an unfinished one");
    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        handshake && o_last && !i_load |=> !r_valid)
        else $error("sequencer kept sending after the final result");
`endif

endmodule

// File: rtl/lmf_core_dp.sv
// Column tracking, window addressing and strength computation of the filter.
module lmf_core_dp #(
    parameter int MAX_TAP  = 31,
    parameter int MAX_COLS = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lmf_pkg::TAP_REG_W-1:0]     i_tap,
    input  logic [lmf_pkg::WIDTH_REG_W-1:0]   i_width,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [lmf_pkg::PIX_W-1:0]         i_pixel,
    output logic                              o_load,
    output lmf_pkg::t_job                     o_job,
    input  logic                              i_free
);
    import lmf_pkg::*;

    localparam int AW = $clog2(2 * MAX_TAP + 1);
    localparam int TW = $clog2(MAX_TAP + 1);
    localparam int CW = $clog2(MAX_COLS);
    localparam int WW = $clog2(MAX_COLS + 1);

    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_col;
    logic [AW-1:0]    r_wp;
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_mark_en;
    logic             r_s1_first;
    logic             r_s1_rend;
    logic [FLUSH_W-1:0] r_s1_flush;

    logic [WW-1:0]    w_eff;
    logic [TW-1:0]    tau;
    logic [CW-1:0]    col;
    logic             last_col;
    logic             has_first;
    logic             mark_en;
    logic             first_rend;
    logic [FLUSH_W-1:0] flush;
    logic             accept;
    logic             s1_any;
    logic             s1_adv;
    logic [AW-1:0]    raddr_m;
    logic [AW-1:0]    raddr_l;
    logic [PIX_W-1:0] pix_m;
    logic [PIX_W-1:0] pix_l;
    logic [PIX_W-1:0] side_max;
    logic [PIX_W-1:0] excess;
    logic [PIX_W-1:0] strength;

    // Effective row width and tap distance.
    always_comb begin
        if (i_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(i_width) > MAX_COLS) begin
            w_eff = WW'(MAX_COLS);
        end else begin
            w_eff = WW'(i_width);
        end
        tau = (int'(i_tap) > MAX_TAP) ? TW'(MAX_TAP) : TW'(i_tap);
    end

    // Column of the arriving pixel and the results it causes.
    always_comb begin
        col        = (int'(r_col) >= int'(w_eff)) ? '0 : r_col;
        last_col   = (int'(col) == int'(w_eff) - 1);
        has_first  = (int'(col) >= int'(tau));
        mark_en    = (tau != '0) && (int'(col) >= 2 * int'(tau));
        first_rend = (tau == '0) && last_col;
        if (!last_col || tau == '0) begin
            flush = '0;
        end else if (int'(tau) < int'(w_eff)) begin
            flush = FLUSH_W'(tau);
        end else begin
            flush = FLUSH_W'(w_eff);
        end
        n_col = last_col ? '0 : col + CW'(1);
    end

    // Handshake: the second stage advances when empty, when it causes nothing or the sequencer is free.
    assign s1_any  = r_s1_first || (r_s1_flush != '0);
    assign s1_adv  = !r_s1_valid || !s1_any || i_free;
    assign o_ready = s1_adv;
    assign accept  = i_valid && s1_adv;
    assign o_load  = r_s1_valid && s1_any && i_free;

    // Taps at tau and 2*tau behind the write pointer.
    assign raddr_m = r_wp - AW'(tau);
    assign raddr_l = r_wp - AW'({tau, 1'b0});

    lmf_window_mem #(
        .AW (AW),
        .DW (PIX_W)
    ) u_window_mem (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (r_wp),
        .i_wdata   (i_pixel),
        .i_re      (accept),
        .i_raddr_a (raddr_m),
        .i_raddr_b (raddr_l),
        .o_rdata_a (pix_m),
        .o_rdata_b (pix_l)
    );

    // Control state of the first stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_wp       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_wp  <= r_wp + AW'(1);
            end
            if (s1_adv) begin
                r_s1_valid <= accept;
            end
        end
    end

    // Payload of the second stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix     <= i_pixel;
            r_s1_mark_en <= mark_en;
            r_s1_first   <= has_first;
            r_s1_rend    <= first_rend;
            r_s1_flush   <= flush;
        end
    end

    // Strength 2*m - l - r - |l - r| equals 2*(m - max(l, r)), clamped to 0..255.
    always_comb begin
        side_max = (pix_l > r_s1_pix) ? pix_l : r_s1_pix;
        excess   = (pix_m > side_max) ? (pix_m - side_max) : '0;
        if (!r_s1_mark_en) begin
            strength = '0;
        end else if (excess[PIX_W-1]) begin
            strength = '1;
        end else begin
            strength = {excess[PIX_W-2:0], 1'b0};
        end
    end

    assign o_job.first      = r_s1_first;
    assign o_job.mark       = strength;
    assign o_job.first_rend = r_s1_rend;
    assign o_job.flush      = r_s1_flush;

`ifndef NO_ASSERTIONS
    a_taps_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_mark_en && !s1_adv |=> $stable(pix_m) && $stable(pix_l))
        else $error("window taps changed while the second stage was stalled");
    a_row_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last_col |=> r_col == '0)
        else $error("column count did not wrap at the end of a row");
    a_pointer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_wp) && $stable(r_col))
        else $error("window pointer moved without an accepted pixel");
`endif

endmodule

// File: rtl/lane_marking_filter_core.sv
// Top level of the lane marking filter: configuration registers and stream ports.
//
// The filter takes one 8-bit grey pixel per cycle and returns, per pixel, the marking
// strength 2*(center - max(left, right)) clamped to 0..255, with taps tau columns to
// either side; results lag the input by tau columns and the first and last tau columns
// of each row are zero. Pixels sit in a 64-entry circular window memory read at two taps
// through registered read ports; a result passes the stage registers and the sequencer register.
// Pixels are taken every cycle while the output is taken every cycle; the last column of
// a row also emits min(tau, row_width) trailing border zeros, one per cycle. These go out
// while the first columns of the next row come in, and those columns give no result, so
// with the output always ready the input never waits. Input ready follows output ready
// within the same cycle. The window memory needs no clearing after reset. tap_distance
// and row_width must be written only while idle; the block itself does not enforce this.
module lane_marking_filter_core #(
    parameter int MAX_TAP  = 31,
    parameter int MAX_COLS = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lmf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [lmf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Pixel input.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [7:0] pixel
    // Marking output.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,  // [7:0] marking
    output logic                              o_m_axis_tlast,  // row_end
    output logic                              o_m_axis_tuser   // [0] last_of_run
);
    import lmf_pkg::*;

    logic [TAP_REG_W-1:0]   r_tap;
    logic [WIDTH_REG_W-1:0] r_width;
    logic                   load;
    logic                   seq_free;
    t_job                   job;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap   <= TAP_RESET;
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TAP_DISTANCE: r_tap   <= i_cfg_data[TAP_REG_W-1:0];
                REG_ROW_WIDTH:    r_width <= i_cfg_data[WIDTH_REG_W-1:0];
            endcase
        end
    end

    lmf_core_dp #(
        .MAX_TAP  (MAX_TAP),
        .MAX_COLS (MAX_COLS)
    ) u_core_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tap   (r_tap),
        .i_width (r_width),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_pixel (i_s_axis_tdata),
        .o_load  (load),
        .o_job   (job),
        .i_free  (seq_free)
    );

    lmf_result_seq u_result_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_job     (job),
        .o_free    (seq_free),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_mark    (o_m_axis_tdata),
        .o_row_end (o_m_axis_tlast),
        .o_last    (o_m_axis_tuser)
    );

endmodule
